// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, disabled while reset is active.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Concurrent check on the rising clock edge that also holds during reset.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/clnws_pkg.sv -----
// Package with the types, codes and sequencer functions of the LCD nibble write sequencer.
`timescale 1ns / 1ps

package clnws_pkg;

	// Request codes.
	localparam logic [2:0] CMD_TICK     = 3'd0;
	localparam logic [2:0] CMD_INSTR    = 3'd1;
	localparam logic [2:0] CMD_DATA     = 3'd2;
	localparam logic [2:0] CMD_POSITION = 3'd3;
	localparam logic [2:0] CMD_GLYPH    = 3'd4;
	localparam logic [2:0] CMD_INIT     = 3'd5;

	// Configuration register indexes.
	localparam logic [2:0] CFG_ENABLE_PULSE = 3'd0;
	localparam logic [2:0] CFG_GAP_HIGH     = 3'd1;
	localparam logic [2:0] CFG_GAP_LOW      = 3'd2;
	localparam logic [2:0] CFG_POWER_WAIT   = 3'd3;
	localparam logic [2:0] CFG_WAIT_FIRST   = 3'd4;
	localparam logic [2:0] CFG_WAIT_CLEAR   = 3'd5;
	localparam logic [2:0] CFG_DISPLAY_MODE = 3'd6;

	// Controller instruction bytes.
	localparam logic [7:0] INIT_WAKE     = 8'h33;
	localparam logic [7:0] INIT_FOUR_BIT = 8'h32;
	localparam logic [7:0] INIT_FUNCTION = 8'h28;
	localparam logic [7:0] INIT_ENTRY    = 8'h06;
	localparam logic [7:0] INIT_DISPLAY  = 8'h0C;
	localparam logic [7:0] INIT_CLEAR    = 8'h01;
	localparam logic [7:0] ADDR_LINE1    = 8'h80;
	localparam logic [7:0] ADDR_LINE2    = 8'hC0;
	localparam logic [7:0] ADDR_GLYPH    = 8'h40;
	localparam logic [7:0] NIBBLE_LOW    = 8'h0F;
	localparam logic [7:0] NIBBLE_HIGH   = 8'hF0;

	// Number of zero-length steps that can chain within one item.
	localparam int SETTLE_STEPS = 4;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_POWER    = 3'd1,
		PH_HI_PULSE = 3'd2,
		PH_HI_GAP   = 3'd3,
		PH_LO_PULSE = 3'd4,
		PH_LO_GAP   = 3'd5,
		PH_EXTRA    = 3'd6
	} phase_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] byte_value;
		logic [1:0] line;
		logic [7:0] column;
		logic [3:0] slot;
	} req_t;

	typedef struct packed {
		logic [3:0] data_nibble;
		logic       register_select;
		logic       enable;
		logic       busy_res;
		logic       accepted;
	} res_t;

	typedef struct packed {
		logic [7:0] enable_pulse_ticks;
		logic [7:0] gap_after_high_nibble;
		logic [7:0] gap_after_low_nibble;
		logic [7:0] power_up_wait_ticks;
		logic [7:0] wait_after_first_init;
		logic [7:0] wait_after_clear;
		logic [1:0] display_mode_bits;
	} cfg_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] tick_count;
		logic [7:0] byte_in_flight;
		logic       select_in_flight;
		logic [2:0] init_step;
		logic [3:0] pin_nibble;
	} seq_state_t;

	// Enable pulse length; a programmed zero counts as one tick.
	function automatic logic [7:0] pulse_len(input cfg_t cfg);
		return (cfg.enable_pulse_ticks == 8'd0) ? 8'd1 : cfg.enable_pulse_ticks;
	endfunction

	// Load a byte and drive its high nibble for the first pulse tick.
	function automatic seq_state_t start_byte(input seq_state_t s, input logic [7:0] b,
			input logic rs, input cfg_t cfg);
		seq_state_t n;
		n = s;
		n.byte_in_flight = b;
		n.select_in_flight = rs;
		n.phase = PH_HI_PULSE;
		n.tick_count = pulse_len(cfg);
		n.pin_nibble = b[7:4];
		return n;
	endfunction

	// Instruction byte for the current init step; any step outside 1 to 5 is the clear.
	function automatic logic [7:0] init_byte(input logic [2:0] step, input cfg_t cfg);
		logic [7:0] b;
		case (step)
			3'd1:    b = INIT_WAKE;
			3'd2:    b = INIT_FOUR_BIT;
			3'd3:    b = INIT_FUNCTION;
			3'd4:    b = INIT_ENTRY;
			3'd5:    b = INIT_DISPLAY | {6'd0, cfg.display_mode_bits};
			default: b = INIT_CLEAR;
		endcase
		return b;
	endfunction

	// One step of the sequencer once the current count has run out.
	function automatic seq_state_t advance(input seq_state_t s, input cfg_t cfg);
		seq_state_t n;
		n = s;
		case (s.phase)
			PH_POWER: begin
				n.init_step = 3'd1;
				n = start_byte(n, init_byte(3'd1, cfg), 1'b0, cfg);
			end
			PH_HI_PULSE: begin
				n.phase = PH_HI_GAP;
				n.tick_count = cfg.gap_after_high_nibble;
			end
			PH_HI_GAP: begin
				n.phase = PH_LO_PULSE;
				n.tick_count = pulse_len(cfg);
				n.pin_nibble = s.byte_in_flight[3:0];
			end
			PH_LO_PULSE: begin
				n.phase = PH_LO_GAP;
				n.tick_count = cfg.gap_after_low_nibble;
			end
			PH_LO_GAP: begin
				if (s.init_step == 3'd1) begin
					n.phase = PH_EXTRA;
					n.tick_count = cfg.wait_after_first_init;
				end else if (s.init_step >= 3'd6) begin
					n.phase = PH_EXTRA;
					n.tick_count = cfg.wait_after_clear;
				end else if (s.init_step >= 3'd2) begin
					n.init_step = s.init_step + 3'd1;
					n = start_byte(n, init_byte(n.init_step, cfg), 1'b0, cfg);
				end else begin
					n.phase = PH_IDLE;
					n.tick_count = 8'd0;
				end
			end
			PH_EXTRA: begin
				if (s.init_step >= 3'd6 || s.init_step == 3'd0) begin
					n.phase = PH_IDLE;
					n.tick_count = 8'd0;
					n.init_step = 3'd0;
				end else begin
					n.init_step = s.init_step + 3'd1;
					n = start_byte(n, init_byte(n.init_step, cfg), 1'b0, cfg);
				end
			end
			default: begin
				n.phase = PH_IDLE;
				n.tick_count = 8'd0;
				n.init_step = 3'd0;
			end
		endcase
		return n;
	endfunction

	// Skip over zero-length waits; at most a few of them chain before a pulse or idle.
	function automatic seq_state_t settle(input seq_state_t s, input cfg_t cfg);
		seq_state_t n;
		n = s;
		for (int i = 0; i < SETTLE_STEPS; i++) begin
			if (n.phase != PH_IDLE && n.tick_count == 8'd0) begin
				n = advance(n, cfg);
			end
		end
		return n;
	endfunction

endpackage

// ----- hw/rtl/char_lcd_nibble_write_sequencer.sv -----
// Top level of the character LCD nibble write sequencer.
`timescale 1ns / 1ps

// Character LCD write sequencer for a 4-bit bus. Every request item (a tick or a
// command) yields exactly one result item showing the pin levels, busy and whether
// the request was taken. One item is accepted per clock cycle unless req_stall is
// high. An accepted request is held in the input register, and when it is processed
// its result is written to the result register, where it is offered to the consumer.
// The result register stalls the input side only when it holds an untaken result
// and the consumer stalls. The configuration port is always ready; a write takes
// effect on the next cycle and is meant to be issued while the sequencer is idle.
// There is no clearing pass after reset.
module char_lcd_nibble_write_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  clnws_pkg::req_t     req,
	output logic                res_valid,
	input  logic                res_stall,
	output clnws_pkg::res_t     res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data
);

	logic                  req_valid_s1;
	clnws_pkg::req_t       req_s1;
	clnws_pkg::cfg_t       cfg_q;
	clnws_pkg::seq_state_t state_q;
	clnws_pkg::seq_state_t state_start;
	clnws_pkg::seq_state_t state_next;
	logic                  accepted_next;
	logic                  res_valid_q;
	clnws_pkg::res_t       res_q;
	logic                  proc;

	// The held request is processed whenever the result register can take its result.
	assign proc      = req_valid_s1 && (!res_valid_q || !res_stall);
	assign req_stall = req_valid_s1 && !proc;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_pulse_ticks    <= 8'd1;
			cfg_q.gap_after_high_nibble <= 8'd5;
			cfg_q.gap_after_low_nibble  <= 8'd2;
			cfg_q.power_up_wait_ticks   <= 8'd20;
			cfg_q.wait_after_first_init <= 8'd1;
			cfg_q.wait_after_clear      <= 8'd2;
			cfg_q.display_mode_bits     <= 2'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				clnws_pkg::CFG_ENABLE_PULSE: cfg_q.enable_pulse_ticks    <= cfg_data;
				clnws_pkg::CFG_GAP_HIGH:     cfg_q.gap_after_high_nibble <= cfg_data;
				clnws_pkg::CFG_GAP_LOW:      cfg_q.gap_after_low_nibble  <= cfg_data;
				clnws_pkg::CFG_POWER_WAIT:   cfg_q.power_up_wait_ticks   <= cfg_data;
				clnws_pkg::CFG_WAIT_FIRST:   cfg_q.wait_after_first_init <= cfg_data;
				clnws_pkg::CFG_WAIT_CLEAR:   cfg_q.wait_after_clear      <= cfg_data;
				clnws_pkg::CFG_DISPLAY_MODE: cfg_q.display_mode_bits     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			req_valid_s1 <= 1'b1;
		end else if (proc) begin
			req_valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	// Apply the held request to the sequencer state before zero waits are skipped.
	always_comb begin
		state_start   = state_q;
		accepted_next = 1'b0;
		if (req_s1.command == clnws_pkg::CMD_TICK) begin
			if (state_q.phase != clnws_pkg::PH_IDLE && state_q.tick_count != 8'd0) begin
				state_start.tick_count = state_q.tick_count - 8'd1;
			end
		end else if (state_q.phase == clnws_pkg::PH_IDLE) begin
			case (req_s1.command)
				clnws_pkg::CMD_INSTR: begin
					accepted_next = 1'b1;
					state_start = clnws_pkg::start_byte(state_q, req_s1.byte_value, 1'b0, cfg_q);
				end
				clnws_pkg::CMD_DATA: begin
					accepted_next = 1'b1;
					state_start = clnws_pkg::start_byte(state_q, req_s1.byte_value, 1'b1, cfg_q);
				end
				clnws_pkg::CMD_POSITION: begin
					if (req_s1.column < 8'd16) begin
						accepted_next = 1'b1;
						if (req_s1.line == 2'd1) begin
							state_start = clnws_pkg::start_byte(state_q,
								clnws_pkg::ADDR_LINE1 | {4'd0, req_s1.column[3:0]}, 1'b0, cfg_q);
						end else if (req_s1.line == 2'd2) begin
							state_start = clnws_pkg::start_byte(state_q,
								clnws_pkg::ADDR_LINE2 | {4'd0, req_s1.column[3:0]}, 1'b0, cfg_q);
						end
					end
				end
				clnws_pkg::CMD_GLYPH: begin
					if (req_s1.slot < 4'd8) begin
						accepted_next = 1'b1;
						state_start = clnws_pkg::start_byte(state_q,
							clnws_pkg::ADDR_GLYPH | {2'd0, req_s1.slot[2:0], 3'd0}, 1'b0, cfg_q);
					end
				end
				clnws_pkg::CMD_INIT: begin
					accepted_next = 1'b1;
					state_start.init_step  = 3'd0;
					state_start.phase      = clnws_pkg::PH_POWER;
					state_start.tick_count = cfg_q.power_up_wait_ticks;
				end
				default: ;
			endcase
		end
	end

	// Skip every wait that has already run out.
	always_comb begin
		state_next = clnws_pkg::settle(state_start, cfg_q);
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase            <= clnws_pkg::PH_IDLE;
			state_q.tick_count       <= 8'd0;
			state_q.byte_in_flight   <= 8'd0;
			state_q.select_in_flight <= 1'b0;
			state_q.init_step        <= 3'd0;
			state_q.pin_nibble       <= 4'd0;
		end else if (proc) begin
			state_q <= state_next;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (proc) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register payload: pin levels after the request.
	always_ff @(posedge clk) begin
		if (proc) begin
			res_q.data_nibble     <= state_next.pin_nibble;
			res_q.register_select <= state_next.select_in_flight;
			res_q.enable          <= (state_next.phase == clnws_pkg::PH_HI_PULSE) ||
				(state_next.phase == clnws_pkg::PH_LO_PULSE);
			res_q.busy_res        <= (state_next.phase != clnws_pkg::PH_IDLE);
			res_q.accepted        <= accepted_next;
		end
	end

endmodule

// ----- hw/rtl/clnws_checker.sv -----
// Port-level checker for the LCD nibble write sequencer and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clnws_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            res_valid,
	input logic            res_stall,
	input clnws_pkg::res_t res
);

	// The enable strobe only pulses while a byte is in progress.
	`ASSERT_CLK(a_enable_busy, res_valid && res.enable |-> res.busy_res, "enable high while not busy")

	// No result is offered in the cycle after reset was active.
	`ASSERT_CLK_ALWAYS(a_reset_empty, !arst_n |=> !res_valid, "result valid right after reset")

	// A stalled result stays offered and unchanged.
	`ASSERT_CLK(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res), "stalled result changed")

endmodule

bind char_lcd_nibble_write_sequencer clnws_checker u_clnws_checker (.*);
